@@ rtl/mkd_pkg.sv @@
// mkd_pkg: shared types and constants for the matrix keypad debouncer
// keypad geometry, debounce phase encoding and the request/result payloads
// no dependencies
`default_nettype none

package mkd_pkg;

  localparam int ROWS        = 4;
  localparam int COLUMNS     = 4;
  localparam int NUM_KEYPADS = 2;

  localparam int KEYS       = ROWS * COLUMNS;
  localparam int LEVEL_BITS = 16;
  localparam int PAD_W      = (NUM_KEYPADS > 1) ? $clog2(NUM_KEYPADS) : 1;
  localparam int KEY_IDX_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int ID_W       = 2;
  localparam int OUT_IDX_W  = 4;
  localparam int CNT_W      = 8;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd5;

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_BAD_ID = 1'b1;

  typedef enum logic [1:0] {
    PH_RELEASED     = 2'd0,
    PH_PRE_PRESSED  = 2'd1,
    PH_PRESSED      = 2'd2,
    PH_PRE_RELEASED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [ID_W-1:0]       pad_num;
    logic [LEVEL_BITS-1:0] key_levels;
  } in_t;

  typedef struct packed {
    logic                 status;
    logic                 key_found;
    logic [OUT_IDX_W-1:0] key_index;
  } out_t;

  // per-request control broadcast to every lane
  typedef struct packed {
    logic             upd;
    logic [PAD_W-1:0] pad;
  } lane_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mkd_lane.sv @@
// mkd_lane: four-phase debouncer of one key position, one state entry per keypad
// depends on mkd_pkg
`default_nettype none

module mkd_lane (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mkd_pkg::lane_ctl_t      ctl,
  input  wire logic                    level,
  input  wire logic [mkd_pkg::CNT_W-1:0] debounce_count,
  output logic                         entered
);

  mkd_pkg::phase_t             phase_r [mkd_pkg::NUM_KEYPADS];
  logic [mkd_pkg::CNT_W-1:0]   hold_r  [mkd_pkg::NUM_KEYPADS];

  mkd_pkg::phase_t             phase_cur;
  mkd_pkg::phase_t             phase_nxt;
  logic [mkd_pkg::CNT_W-1:0]   hold_cur;
  logic [mkd_pkg::CNT_W-1:0]   hold_nxt;
  logic [mkd_pkg::CNT_W-1:0]   cnt;
  logic                        want_pressed;
  logic                        agree;
  logic                        adv;

  assign phase_cur = phase_r[ctl.pad];
  assign hold_cur  = hold_r[ctl.pad];

  assign want_pressed = (phase_cur == mkd_pkg::PH_RELEASED) ||
                        (phase_cur == mkd_pkg::PH_PRE_PRESSED);
  assign agree   = (level == want_pressed);
  assign cnt     = hold_cur + 1'b1;   // wraps at 8 bits
  assign adv     = agree && (cnt >= debounce_count);
  assign entered = adv && (phase_cur == mkd_pkg::PH_PRE_PRESSED);

  always_comb begin
    phase_nxt = phase_cur;
    if (adv) begin
      unique case (phase_cur)
        mkd_pkg::PH_RELEASED:     phase_nxt = mkd_pkg::PH_PRE_PRESSED;
        mkd_pkg::PH_PRE_PRESSED:  phase_nxt = mkd_pkg::PH_PRESSED;
        mkd_pkg::PH_PRESSED:      phase_nxt = mkd_pkg::PH_PRE_RELEASED;
        mkd_pkg::PH_PRE_RELEASED: phase_nxt = mkd_pkg::PH_RELEASED;
        default:                  phase_nxt = mkd_pkg::PH_RELEASED;
      endcase
    end
  end

  assign hold_nxt = (agree && !adv) ? cnt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < mkd_pkg::NUM_KEYPADS; p++) begin
        phase_r[p] <= mkd_pkg::PH_RELEASED;
        hold_r[p]  <= '0;
      end
    end else if (ctl.upd) begin
      phase_r[ctl.pad] <= phase_nxt;
      hold_r[ctl.pad]  <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mkd_merge.sv @@
// mkd_merge: picks the first lane that entered the pressed phase and holds the result
// output register with its valid flag; depends on mkd_pkg
`default_nettype none

module mkd_merge (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire logic                      bad_id,
  input  wire logic [mkd_pkg::KEYS-1:0]  entered,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output mkd_pkg::out_t                  out_data
);

  logic                            valid_r;
  logic                            valid_nxt;
  mkd_pkg::out_t                   data_r;
  mkd_pkg::out_t                   data_nxt;
  logic [mkd_pkg::KEY_IDX_W-1:0]   first;
  logic                            any;

  // lowest index wins
  always_comb begin
    first = '0;
    for (int k = mkd_pkg::KEYS - 1; k >= 0; k--) begin
      if (entered[k]) first = mkd_pkg::KEY_IDX_W'(k);
    end
  end

  assign any = |entered;

  always_comb begin
    data_nxt = '0;
    if (bad_id) begin
      data_nxt.status = mkd_pkg::ST_BAD_ID;
    end else begin
      data_nxt.status    = mkd_pkg::ST_OK;
      data_nxt.key_found = any;
      data_nxt.key_index = any ? mkd_pkg::OUT_IDX_W'(first) : '0;
    end
  end

  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/matrix_keypad_debouncer_core.sv @@
// matrix_keypad_debouncer_core: top level of the keypad scan debouncer
// one mkd_lane per key position, mkd_merge for the result; depends on mkd_pkg
//
// usage: each request on in_* carries one full scan of one keypad (pad_num and
// one pressed bit per key). every key of that keypad steps its own four-phase
// debouncer (released, pre-pressed, pressed, pre-released) in its own lane.
// one result per request on out_*: status, key_found and the index of the first
// key in row-major order that reached the pressed phase on this scan. a keypad
// number at or above the keypad count gives the error status and leaves state alone.
// the result is registered and valid the cycle after the request is accepted.
// throughput: one request per cycle; lane state is read from registers and
// written back at the accepting edge, so scans of the same keypad may follow
// directly. in_ready is high whenever the output register is empty or being
// taken, so a stalled receiver holds at most one result and stalls the input.
// cfg_we/cfg_data write debounce_count at once (write only while idle).
// reset (synchronous, rst_n low): all keys released, hold counters zero,
// debounce_count 5, no result pending.
`default_nettype none

module matrix_keypad_debouncer_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mkd_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output mkd_pkg::out_t                   out_data,
  input  wire logic                       cfg_we,
  input  wire logic [mkd_pkg::CNT_W-1:0]  cfg_data
);

  logic [mkd_pkg::CNT_W-1:0] debounce_r;
  logic                      accept;
  logic                      bad_id;
  mkd_pkg::lane_ctl_t        ctl;
  logic [mkd_pkg::KEYS-1:0]  entered;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= mkd_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_r <= cfg_data;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign bad_id   = (int'(in_data.pad_num) >= mkd_pkg::NUM_KEYPADS);

  assign ctl.upd = accept && !bad_id;
  assign ctl.pad = in_data.pad_num[mkd_pkg::PAD_W-1:0];

  for (genvar k = 0; k < mkd_pkg::KEYS; k++) begin : g_lane
    logic level;
    // keys past the level field always read released
    if (k < mkd_pkg::LEVEL_BITS) begin : g_bit
      assign level = in_data.key_levels[k];
    end else begin : g_none
      assign level = 1'b0;
    end

    mkd_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (ctl),
      .level          (level),
      .debounce_count (debounce_r),
      .entered        (entered[k])
    );
  end

  mkd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .bad_id    (bad_id),
    .entered   (entered),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_bad_id_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept && bad_id |=> out_valid && out_data.status == mkd_pkg::ST_BAD_ID)
    else $error("bad keypad id did not give error status");

  a_error_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == mkd_pkg::ST_BAD_ID |->
      !out_data.key_found && out_data.key_index == '0)
    else $error("error result carries a key");

  a_index_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.key_found |-> out_data.key_index == '0)
    else $error("key index nonzero without a key");

  a_ready_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_load_valid : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire

@@ test/tb_matrix_keypad_debouncer_core.sv @@
// tb_matrix_keypad_debouncer_core: self-checking bench for the keypad scan debouncer
// a directed scan table and then random held/glitched scans, checked against a
// per-key debounce predictor; depends on mkd_pkg and matrix_keypad_debouncer_core
`default_nettype none

module tb_matrix_keypad_debouncer_core;

  typedef enum logic {
    ROW_SCAN,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [mkd_pkg::ID_W-1:0]       pad_num;
    logic [mkd_pkg::LEVEL_BITS-1:0] key_levels;
    logic [mkd_pkg::CNT_W-1:0]      cfg_value;
    bit                             has_exp;
    mkd_pkg::out_t                  exp;
  } scan_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  mkd_pkg::in_t              in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  mkd_pkg::out_t             out_data;
  logic                      cfg_we = 1'b0;
  logic [mkd_pkg::CNT_W-1:0] cfg_data = '0;

  // debounce predictor state
  mkd_pkg::phase_t           pad_phase [mkd_pkg::NUM_KEYPADS][mkd_pkg::KEYS];
  logic [mkd_pkg::CNT_W-1:0] pad_hold  [mkd_pkg::NUM_KEYPADS][mkd_pkg::KEYS];
  logic [mkd_pkg::CNT_W-1:0] debounce_len;

  // random scan shaping: the level pattern each pad is held at, and for how long
  logic [mkd_pkg::LEVEL_BITS-1:0] pad_target    [mkd_pkg::NUM_KEYPADS];
  int                             pad_runs_left [mkd_pkg::NUM_KEYPADS];

  mkd_pkg::out_t pending_scan_results [$];
  scan_row_t     directed_rows [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int scans_sent = 0;
  int presses_seen = 0;
  int bad_ids_seen = 0;
  int cfg_writes = 0;

  matrix_keypad_debouncer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("matrix_keypad_debouncer_core: mismatch");
    $finish;
  end

  task automatic clear_debouncers();
    for (int p = 0; p < mkd_pkg::NUM_KEYPADS; p++) begin
      for (int k = 0; k < mkd_pkg::KEYS; k++) begin
        pad_phase[p][k] = mkd_pkg::PH_RELEASED;
        pad_hold[p][k]  = '0;
      end
      pad_target[p]    = '0;
      pad_runs_left[p] = 0;
    end
    debounce_len = mkd_pkg::DEBOUNCE_RESET;
  endtask

  // steps every key of the scanned pad and returns the expected result
  task automatic debounce_scan(input mkd_pkg::in_t req, output mkd_pkg::out_t res);
    logic [mkd_pkg::CNT_W-1:0] next_hold;
    logic                      pressed;
    logic                      want_pressed;
    mkd_pkg::phase_t           ph;
    int                        pad;
    res = '0;
    res.status = mkd_pkg::ST_OK;
    if (req.pad_num >= mkd_pkg::NUM_KEYPADS) begin
      res.status = mkd_pkg::ST_BAD_ID;
      return;
    end
    pad = req.pad_num;
    for (int k = 0; k < mkd_pkg::KEYS; k++) begin
      ph = pad_phase[pad][k];
      want_pressed = (ph == mkd_pkg::PH_RELEASED) || (ph == mkd_pkg::PH_PRE_PRESSED);
      // keys past the level field always read released
      pressed = (k < mkd_pkg::LEVEL_BITS) ? req.key_levels[k] : 1'b0;
      if (pressed != want_pressed) begin
        pad_hold[pad][k] = '0;
      end else begin
        next_hold = pad_hold[pad][k] + 8'd1;
        // >= so a count of zero acts as one and a lowered count fires at once
        if (next_hold >= debounce_len) begin
          if (ph == mkd_pkg::PH_PRE_PRESSED && !res.key_found) begin
            res.key_found = 1'b1;
            res.key_index = mkd_pkg::OUT_IDX_W'(k);
          end
          pad_phase[pad][k] = mkd_pkg::phase_t'(ph + 2'd1);
          pad_hold[pad][k]  = '0;
        end else begin
          pad_hold[pad][k] = next_hold;
        end
      end
    end
  endtask

  task automatic send_scan(input mkd_pkg::in_t req, input bit has_exp,
                           input mkd_pkg::out_t typed);
    mkd_pkg::out_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    debounce_scan(req, predicted);
    pending_scan_results.push_back(has_exp ? typed : predicted);
    scans_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_scan_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [mkd_pkg::CNT_W-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_len = value;
    cfg_writes++;
  endtask

  task automatic add_scan(input logic [mkd_pkg::ID_W-1:0] id,
                          input logic [mkd_pkg::LEVEL_BITS-1:0] levels,
                          input bit has_exp, input logic st, input logic found,
                          input logic [mkd_pkg::OUT_IDX_W-1:0] idx);
    scan_row_t row;
    row.kind          = ROW_SCAN;
    row.pad_num       = id;
    row.key_levels    = levels;
    row.cfg_value     = '0;
    row.has_exp       = has_exp;
    row.exp.status    = st;
    row.exp.key_found = found;
    row.exp.key_index = idx;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [mkd_pkg::CNT_W-1:0] value);
    scan_row_t row;
    row = '{kind: ROW_CFG, pad_num: '0, key_levels: '0, cfg_value: value,
            has_exp: 1'b0, exp: '0};
    directed_rows.push_back(row);
  endtask

  // mostly held patterns (one key, none, or many) with rare glitches,
  // plus some pure noise and some scans of keypads that do not exist
  task automatic next_random_scan(output mkd_pkg::in_t req);
    int r;
    int p;
    int eff;
    r = $urandom_range(99);
    if (r < 8) begin
      req.pad_num    = mkd_pkg::ID_W'($urandom_range(3, mkd_pkg::NUM_KEYPADS));
      req.key_levels = mkd_pkg::LEVEL_BITS'($urandom);
      return;
    end
    p = $urandom_range(mkd_pkg::NUM_KEYPADS - 1);
    req.pad_num = mkd_pkg::ID_W'(p);
    if (r < 14) begin
      req.key_levels = mkd_pkg::LEVEL_BITS'($urandom);
      return;
    end
    if (pad_runs_left[p] == 0) begin
      eff = (debounce_len == 0) ? 1 : int'(debounce_len);
      pad_runs_left[p] = $urandom_range(3 * eff + 3, 1);
      r = $urandom_range(99);
      if (r < 60) begin
        pad_target[p] = mkd_pkg::LEVEL_BITS'(1) << $urandom_range(mkd_pkg::LEVEL_BITS - 1);
      end else if (r < 80) begin
        pad_target[p] = '0;
      end else begin
        pad_target[p] = mkd_pkg::LEVEL_BITS'($urandom);
      end
    end
    pad_runs_left[p]--;
    req.key_levels = pad_target[p];
    if ($urandom_range(9) == 0) begin
      req.key_levels ^= mkd_pkg::LEVEL_BITS'(1) << $urandom_range(mkd_pkg::LEVEL_BITS - 1);
    end
  endtask

  always @(posedge clk) begin : result_check
    mkd_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_data.key_found) presses_seen++;
      if (out_data.status == mkd_pkg::ST_BAD_ID) bad_ids_seen++;
      if (pending_scan_results.size() == 0) begin
        $display("%0t: result with no request pending, got %p", $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_scan_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.key_found !== want.key_found) begin
          $display("%0t: key_found expected %0d got %0d", $time, want.key_found,
                   out_data.key_found);
          mismatch_count++;
        end
        if (out_data.key_index !== want.key_index) begin
          $display("%0t: key_index expected %0d got %0d", $time, want.key_index,
                   out_data.key_index);
          mismatch_count++;
        end
      end
    end
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int            phase_counts [8];
    int            idle_send [4];
    int            idle_recv [4];
    mkd_pkg::in_t  req;
    mkd_pkg::out_t no_exp;
    phase_counts = '{1, 2, 3, 0, 4, 255, 1, 2};
    idle_send    = '{0, 57, 0, 28};
    idle_recv    = '{0, 0, 57, 28};
    no_exp = '0;
    clear_debouncers();

    // reset count is 5, so a first scan never finds a press
    add_scan(0, 16'hFFFF, 1, mkd_pkg::ST_OK, 0, 0);
    add_scan(2, 16'hFFFF, 1, mkd_pkg::ST_BAD_ID, 0, 0);
    add_scan(3, 16'h0000, 1, mkd_pkg::ST_BAD_ID, 0, 0);
    add_scan(1, 16'h0000, 1, mkd_pkg::ST_OK, 0, 0);
    repeat (5) add_scan(0, 16'hFFFF, 0, mkd_pkg::ST_OK, 0, 0);
    add_scan(3, 16'hFFFF, 1, mkd_pkg::ST_BAD_ID, 0, 0);
    add_cfg(8'd1);
    add_scan(1, 16'h8000, 1, mkd_pkg::ST_OK, 0, 0);
    add_scan(1, 16'h8000, 1, mkd_pkg::ST_OK, 1, 15);
    add_scan(1, 16'h0000, 0, mkd_pkg::ST_OK, 0, 0);
    add_scan(1, 16'h0000, 0, mkd_pkg::ST_OK, 0, 0);
    add_scan(0, 16'h00F0, 0, mkd_pkg::ST_OK, 0, 0);
    // zero count behaves as one
    add_cfg(8'd0);
    add_scan(0, 16'h0F0F, 0, mkd_pkg::ST_OK, 0, 0);
    add_scan(0, 16'h0F0F, 0, mkd_pkg::ST_OK, 0, 0);
    add_cfg(8'd255);
    add_scan(0, 16'hAAAA, 0, mkd_pkg::ST_OK, 0, 0);
    add_scan(1, 16'h5555, 0, mkd_pkg::ST_OK, 0, 0);
    // build up holds, then lower the count under them
    add_cfg(8'd4);
    add_scan(1, 16'h0001, 0, mkd_pkg::ST_OK, 0, 0);
    add_scan(1, 16'h0001, 0, mkd_pkg::ST_OK, 0, 0);
    add_scan(1, 16'h0001, 0, mkd_pkg::ST_OK, 0, 0);
    add_cfg(8'd1);
    add_scan(1, 16'h0001, 0, mkd_pkg::ST_OK, 0, 0);
    add_scan(1, 16'h0001, 0, mkd_pkg::ST_OK, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_debounce(directed_rows[i].cfg_value);
      end else begin
        req.pad_num    = directed_rows[i].pad_num;
        req.key_levels = directed_rows[i].key_levels;
        send_scan(req, directed_rows[i].has_exp, directed_rows[i].exp);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_debounce(mkd_pkg::CNT_W'(phase_counts[ph]));
      send_idle_pct  = idle_send[ph % 4];
      recv_stall_pct = idle_recv[ph % 4];
      for (int n = 0; n < 110; n++) begin
        // let the pipe run dry once in the middle of a stalling phase
        if (ph == 2 && n == 55) drain_results();
        next_random_scan(req);
        send_scan(req, 0, no_exp);
      end
    end

    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);

    $display("ran %0d scans over %0d debounce count writes (0, 1, 255 among them)",
             scans_sent, cfg_writes);
    $display("results: %0d reported a new press, %0d flagged a bad keypad id",
             presses_seen, bad_ids_seen);
    if (mismatch_count == 0 && pending_scan_results.size() == 0) begin
      $display("matrix_keypad_debouncer_core: match");
    end else begin
      $display("matrix_keypad_debouncer_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
